// File: hw/rtl/admin_record_byte_parser_top_macros.svh
// ----------------------------------------------------------------------------
// admin record byte parser assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ADMIN_RECORD_BYTE_PARSER_TOP_MACROS_SVH
`define ADMIN_RECORD_BYTE_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define ABRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ABRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/abrp_pkg.sv
// ----------------------------------------------------------------------------
// abrp_pkg
// types and codes for the administrative record byte parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abrp_pkg;

    // parse status codes
    localparam logic [1:0] PS_GOING = 2'd0;
    localparam logic [1:0] PS_DONE  = 2'd1;
    localparam logic [1:0] PS_ERR   = 2'd2;

    // field codes reported with a completed field
    localparam logic [3:0] FC_TYPE    = 4'd0;
    localparam logic [3:0] FC_STATUS  = 4'd1;
    localparam logic [3:0] FC_REASON  = 4'd2;
    localparam logic [3:0] FC_CUSTODY = 4'd3;
    localparam logic [3:0] FC_FOFF    = 4'd4;
    localparam logic [3:0] FC_FLEN    = 4'd5;
    localparam logic [3:0] FC_EVS     = 4'd6;
    localparam logic [3:0] FC_EVNS    = 4'd7;
    localparam logic [3:0] FC_CREATE  = 4'd8;
    localparam logic [3:0] FC_SEQ     = 4'd9;
    localparam logic [3:0] FC_EIDLEN  = 4'd10;
    localparam logic [3:0] FC_EID     = 4'd11;

    // record type nibbles
    localparam logic [3:0] TYPE_STATUS_REPORT = 4'd1;
    localparam logic [3:0] TYPE_CUSTODY       = 4'd2;

    // parser stage, one-hot
    typedef enum logic [11:0] {
        STG_TYPE    = 12'b0000_0000_0001,
        STG_STATUS  = 12'b0000_0000_0010,
        STG_REASON  = 12'b0000_0000_0100,
        STG_CUSTODY = 12'b0000_0000_1000,
        STG_FOFF    = 12'b0000_0001_0000,
        STG_FLEN    = 12'b0000_0010_0000,
        STG_EVS     = 12'b0000_0100_0000,
        STG_EVNS    = 12'b0000_1000_0000,
        STG_CREATE  = 12'b0001_0000_0000,
        STG_SEQ     = 12'b0010_0000_0000,
        STG_EIDLEN  = 12'b0100_0000_0000,
        STG_EID     = 12'b1000_0000_0000
    } stage_t;

    // one result transaction
    typedef struct packed {
        logic [1:0]  parse_status;
        logic        field_valid;
        logic [3:0]  field_code;
        logic [63:0] field_value;
        logic [3:0]  record_flags;
    } result_t;

endpackage

// File: hw/rtl/admin_record_byte_parser_top.sv
// ----------------------------------------------------------------------------
// admin_record_byte_parser_top
// byte-serial parser for status reports and custody signals, one result
// transaction per input byte
// ----------------------------------------------------------------------------
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, in_byte, record_start,       | sink
//          | last_byte                                        |
//  out     | out_valid, out_stall, parse_status, field_valid, | source
//          | field_code, field_value, record_flags            |
//
//  one byte accepted per cycle while in_stall is low; its result is
//  registered in the output register, else in the skid entry. the parser
//  state updates at the accept edge by a shift-or into the sdnv accumulator
//  and a stage change. a two-entry output buffer (output register plus skid)
//  lets a byte in while a result waits; in_stall rises only when both
//  entries are full. reset clears the parser state and empties the buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module admin_record_byte_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        record_start,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  parse_status,
    output logic        field_valid,
    output logic [3:0]  field_code,
    output logic [63:0] field_value,
    output logic [3:0]  record_flags
);

`include "admin_record_byte_parser_top_macros.svh"

    // parser state
    abrp_pkg::stage_t stage_reg, stage_next, stage_eff;
    logic [1:0]       ps_reg, ps_next, ps_eff;
    logic [3:0]       flags_reg, flags_next, flags_eff;
    logic [63:0]      acc_reg, acc_next, acc_eff, acc_shift;
    logic [15:0]      eid_left_reg, eid_left_next, eid_left_eff, eid_dec;

    // output buffer
    logic               out_valid_reg, skid_valid_reg;
    abrp_pkg::result_t  out_res_reg, skid_res_reg, res_new;

    logic in_fire, out_fire, sdnv_ovf;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    // record start resets the parser ahead of this byte
    always_comb
    begin
        if (record_start)
        begin
            stage_eff    = abrp_pkg::STG_TYPE;
            ps_eff       = abrp_pkg::PS_GOING;
            flags_eff    = 4'd0;
            acc_eff      = 64'd0;
            eid_left_eff = 16'd0;
        end
        else
        begin
            stage_eff    = stage_reg;
            ps_eff       = ps_reg;
            flags_eff    = flags_reg;
            acc_eff      = acc_reg;
            eid_left_eff = eid_left_reg;
        end
    end

    assign acc_shift = {acc_eff[56:0], in_byte[6:0]};
    assign eid_dec   = eid_left_eff - 16'd1;

    // overflow when one more 7-bit group would exceed the field range
    always_comb
    begin
        case (stage_eff)
            abrp_pkg::STG_FOFF,
            abrp_pkg::STG_FLEN,
            abrp_pkg::STG_EVNS:   sdnv_ovf = (acc_eff[63:25] != 39'd0);
            abrp_pkg::STG_EIDLEN: sdnv_ovf = (acc_eff[63:9] != 55'd0);
            default:              sdnv_ovf = (acc_eff[63:57] != 7'd0);
        endcase
    end

    // next state and result for one byte
    always_comb
    begin
        stage_next    = stage_eff;
        ps_next       = ps_eff;
        flags_next    = flags_eff;
        acc_next      = acc_eff;
        eid_left_next = eid_left_eff;
        res_new.field_valid = 1'b0;
        res_new.field_code  = abrp_pkg::FC_TYPE;
        res_new.field_value = 64'd0;

        if (ps_eff == abrp_pkg::PS_GOING)
        begin
            unique case (stage_eff) inside
                abrp_pkg::STG_TYPE:
                begin
                    flags_next          = in_byte[3:0];
                    res_new.field_valid = 1'b1;
                    res_new.field_code  = abrp_pkg::FC_TYPE;
                    res_new.field_value = {60'd0, in_byte[7:4]};
                    if (in_byte[7:4] == abrp_pkg::TYPE_STATUS_REPORT)
                        stage_next = abrp_pkg::STG_STATUS;
                    else if (in_byte[7:4] == abrp_pkg::TYPE_CUSTODY)
                        stage_next = abrp_pkg::STG_CUSTODY;
                    else
                        ps_next = abrp_pkg::PS_ERR;
                end
                abrp_pkg::STG_STATUS:
                begin
                    res_new.field_valid = 1'b1;
                    res_new.field_code  = abrp_pkg::FC_STATUS;
                    res_new.field_value = {56'd0, in_byte};
                    stage_next          = abrp_pkg::STG_REASON;
                end
                abrp_pkg::STG_REASON,
                abrp_pkg::STG_CUSTODY:
                begin
                    res_new.field_valid = 1'b1;
                    res_new.field_code  = (stage_eff == abrp_pkg::STG_REASON)
                                          ? abrp_pkg::FC_REASON : abrp_pkg::FC_CUSTODY;
                    res_new.field_value = {56'd0, in_byte};
                    stage_next          = flags_eff[0] ? abrp_pkg::STG_FOFF
                                                       : abrp_pkg::STG_EVS;
                    acc_next            = 64'd0;
                end
                abrp_pkg::STG_EID:
                begin
                    res_new.field_valid = 1'b1;
                    res_new.field_code  = abrp_pkg::FC_EID;
                    res_new.field_value = {56'd0, in_byte};
                    eid_left_next       = eid_dec;
                    if (eid_dec == 16'd0)
                        ps_next = abrp_pkg::PS_DONE;
                end
                abrp_pkg::STG_FOFF, abrp_pkg::STG_FLEN, abrp_pkg::STG_EVS,
                abrp_pkg::STG_EVNS, abrp_pkg::STG_CREATE, abrp_pkg::STG_SEQ,
                abrp_pkg::STG_EIDLEN:
                begin
                    if (sdnv_ovf)
                        ps_next = abrp_pkg::PS_ERR;
                    else if (in_byte[7])
                        acc_next = acc_shift;
                    else
                    begin
                        // sdnv group ends here
                        acc_next            = 64'd0;
                        res_new.field_valid = 1'b1;
                        res_new.field_value = acc_shift;
                        case (stage_eff)
                            abrp_pkg::STG_FOFF:
                            begin
                                res_new.field_code = abrp_pkg::FC_FOFF;
                                stage_next         = abrp_pkg::STG_FLEN;
                            end
                            abrp_pkg::STG_FLEN:
                            begin
                                res_new.field_code = abrp_pkg::FC_FLEN;
                                stage_next         = abrp_pkg::STG_EVS;
                            end
                            abrp_pkg::STG_EVS:
                            begin
                                res_new.field_code = abrp_pkg::FC_EVS;
                                stage_next         = abrp_pkg::STG_EVNS;
                            end
                            abrp_pkg::STG_EVNS:
                            begin
                                res_new.field_code = abrp_pkg::FC_EVNS;
                                stage_next         = abrp_pkg::STG_CREATE;
                            end
                            abrp_pkg::STG_CREATE:
                            begin
                                res_new.field_code = abrp_pkg::FC_CREATE;
                                stage_next         = abrp_pkg::STG_SEQ;
                            end
                            abrp_pkg::STG_SEQ:
                            begin
                                res_new.field_code = abrp_pkg::FC_SEQ;
                                stage_next         = abrp_pkg::STG_EIDLEN;
                            end
                            default:
                            begin
                                res_new.field_code = abrp_pkg::FC_EIDLEN;
                                stage_next         = abrp_pkg::STG_EID;
                                eid_left_next      = acc_shift[15:0];
                                if (acc_shift[15:0] == 16'd0)
                                    ps_next = abrp_pkg::PS_DONE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    ps_next = abrp_pkg::PS_ERR;
                end
            endcase

            // early last byte
            if (last_byte && ps_next == abrp_pkg::PS_GOING)
                ps_next = abrp_pkg::PS_ERR;
        end

        res_new.parse_status = ps_next;
        res_new.record_flags = flags_next;
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg    <= abrp_pkg::STG_TYPE;
            ps_reg       <= abrp_pkg::PS_GOING;
            flags_reg    <= 4'd0;
            acc_reg      <= 64'd0;
            eid_left_reg <= 16'd0;
        end
        else if (in_fire)
        begin
            stage_reg    <= stage_next;
            ps_reg       <= ps_next;
            flags_reg    <= flags_next;
            acc_reg      <= acc_next;
            eid_left_reg <= eid_left_next;
        end
    end

    // output register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
                out_res_reg <= res_new;
            else
                skid_res_reg <= res_new;
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_res_reg <= skid_res_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign parse_status = out_res_reg.parse_status;
    assign field_valid  = out_res_reg.field_valid;
    assign field_code   = out_res_reg.field_code;
    assign field_value  = out_res_reg.field_value;
    assign record_flags = out_res_reg.record_flags;

    // checks
    `ABRP_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid entry held with empty output register")
    `ABRP_ASSERT_NOW(a_done_no_eid_left, ps_reg == abrp_pkg::PS_DONE, eid_left_reg == 16'd0,
        "record complete with eid bytes still pending")
    `ABRP_ASSERT_NEXT(a_status_sticky,
        in_fire && !record_start && ps_reg != abrp_pkg::PS_GOING, $stable(ps_reg),
        "final parse status changed without record start")
    `ABRP_ASSERT_NOW(a_idle_field_zero, out_valid_reg && !out_res_reg.field_valid,
        out_res_reg.field_code == abrp_pkg::FC_TYPE && out_res_reg.field_value == 64'd0,
        "field code or value nonzero without a completed field")

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the administrative record byte parser one byte at a time. A built-in
// model of the parser predicts the result for every byte the block takes in.
// Each result the block hands out is compared with the oldest prediction.
// Stimulus opens with a few hand-picked records. Random records follow, most
// of them well formed, with truncated, unterminated and padded records and
// loose bytes mixed in. Both sides pause at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import abrp_pkg::*;

    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 250000;

    // parser model plus the queue of results still owed by the block
    class record_parser_scoreboard;
        stage_t      stg;
        logic [1:0]  pst;
        logic [3:0]  flags;
        logic [63:0] acc;
        logic [15:0] eid_left;
        result_t     parser_results[$];
        int          n_errors;
        int          n_results;
        int          n_parsed;

        function new();
            clear_parser();
            n_errors  = 0;
            n_results = 0;
            n_parsed  = 0;
        endfunction

        function void clear_parser();
            stg      = STG_TYPE;
            pst      = PS_GOING;
            flags    = 4'd0;
            acc      = 64'd0;
            eid_left = 16'd0;
        endfunction

        // advance the model by one accepted byte and queue its result
        function void parse_byte(logic [7:0] b, logic s, logic l);
            result_t     r;
            logic [63:0] lim;
            logic [3:0]  code;
            stage_t      nxt;
            r = '0;
            if (s)
                clear_parser();
            if (pst == PS_GOING)
            begin
                n_parsed++;
                case (stg)
                    STG_TYPE:
                    begin
                        flags = b[3:0];
                        r.field_valid = 1'b1;
                        r.field_code  = FC_TYPE;
                        r.field_value = {60'd0, b[7:4]};
                        if (b[7:4] == TYPE_STATUS_REPORT)
                            stg = STG_STATUS;
                        else if (b[7:4] == TYPE_CUSTODY)
                            stg = STG_CUSTODY;
                        else
                            pst = PS_ERR;
                    end
                    STG_STATUS:
                    begin
                        r.field_valid = 1'b1;
                        r.field_code  = FC_STATUS;
                        r.field_value = {56'd0, b};
                        stg = STG_REASON;
                    end
                    STG_REASON, STG_CUSTODY:
                    begin
                        r.field_valid = 1'b1;
                        r.field_code  = (stg == STG_REASON) ? FC_REASON : FC_CUSTODY;
                        r.field_value = {56'd0, b};
                        if (flags[0])
                            stg = STG_FOFF;
                        else
                            stg = STG_EVS;
                        acc = 64'd0;
                    end
                    STG_EID:
                    begin
                        r.field_valid = 1'b1;
                        r.field_code  = FC_EID;
                        r.field_value = {56'd0, b};
                        eid_left = eid_left - 16'd1;
                        if (eid_left == 16'd0)
                            pst = PS_DONE;
                    end
                    default:
                    begin
                        // sdnv fields: range and successor per stage
                        lim = {64{1'b1}};
                        nxt = STG_EID;
                        case (stg)
                            STG_FOFF:
                            begin
                                code = FC_FOFF;
                                lim  = 64'hFFFF_FFFF;
                                nxt  = STG_FLEN;
                            end
                            STG_FLEN:
                            begin
                                code = FC_FLEN;
                                lim  = 64'hFFFF_FFFF;
                                nxt  = STG_EVS;
                            end
                            STG_EVS:
                            begin
                                code = FC_EVS;
                                nxt  = STG_EVNS;
                            end
                            STG_EVNS:
                            begin
                                code = FC_EVNS;
                                lim  = 64'hFFFF_FFFF;
                                nxt  = STG_CREATE;
                            end
                            STG_CREATE:
                            begin
                                code = FC_CREATE;
                                nxt  = STG_SEQ;
                            end
                            STG_SEQ:
                            begin
                                code = FC_SEQ;
                                nxt  = STG_EIDLEN;
                            end
                            default:
                            begin
                                code = FC_EIDLEN;
                                lim  = 64'hFFFF;
                                nxt  = STG_EID;
                            end
                        endcase
                        if (acc > (lim >> 7))
                        begin
                            pst = PS_ERR;
                        end
                        else
                        begin
                            acc = {acc[56:0], b[6:0]};
                            if (!b[7])
                            begin
                                r.field_valid = 1'b1;
                                r.field_code  = code;
                                r.field_value = acc;
                                if (stg == STG_EIDLEN)
                                begin
                                    eid_left = acc[15:0];
                                    if (eid_left == 16'd0)
                                        pst = PS_DONE;
                                end
                                stg = nxt;
                                acc = 64'd0;
                            end
                        end
                    end
                endcase
                if (l && pst == PS_GOING)
                    pst = PS_ERR;
            end
            r.parse_status = pst;
            r.record_flags = flags;
            parser_results.push_back(r);
        endfunction

        task report(string msg);
            n_errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // compare one result transaction with the oldest owed one
        task check_result(result_t got);
            result_t want;
            if (parser_results.size() == 0)
            begin
                report("result transaction with no byte outstanding");
                return;
            end
            want = parser_results.pop_front();
            n_results++;
            if (got.parse_status !== want.parse_status)
                report($sformatf("result %0d parse_status %0d, model %0d",
                                 n_results, got.parse_status, want.parse_status));
            if (got.field_valid !== want.field_valid)
                report($sformatf("result %0d field_valid %0b, model %0b",
                                 n_results, got.field_valid, want.field_valid));
            if (got.field_code !== want.field_code)
                report($sformatf("result %0d field_code %0d, model %0d",
                                 n_results, got.field_code, want.field_code));
            if (got.field_value !== want.field_value)
                report($sformatf("result %0d field_value %h, model %h",
                                 n_results, got.field_value, want.field_value));
            if (got.record_flags !== want.record_flags)
                report($sformatf("result %0d record_flags %h, model %h",
                                 n_results, got.record_flags, want.record_flags));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        record_start;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  parse_status;
    logic        field_valid;
    logic [3:0]  field_code;
    logic [63:0] field_value;
    logic [3:0]  record_flags;

    record_parser_scoreboard sb = new();

    logic [7:0] record_bytes[$];
    int         burst_left = 0;
    int         stall_run = 0;
    int         stall_mode = 0;
    int         stall_phase = 0;
    int         cycles = 0;

    admin_record_byte_parser_top DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .record_start (record_start),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .parse_status (parse_status),
        .field_valid  (field_valid),
        .field_code   (field_code),
        .field_value  (field_value),
        .record_flags (record_flags)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // watch both channels at the rising edge
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.parse_status = parse_status;
                got.field_valid  = field_valid;
                got.field_code   = field_code;
                got.field_value  = field_value;
                got.record_flags = record_flags;
                sb.check_result(got);
            end
            if (in_valid && !in_stall)
                sb.parse_byte(in_byte, record_start, last_byte);
        end
    end

    // receiver stall, switching between a few patterns
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (stall_run == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_run  = $urandom_range(20, 150);
            end
            stall_run--;
            stall_phase++;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ((stall_phase % 7) < 3);
                default: out_stall <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // sender bursts and gaps
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    // one input transaction; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic s, input logic l);
        pace_sender();
        in_valid     <= 1'b1;
        in_byte      <= b;
        record_start <= s;
        last_byte    <= l;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // hold off the sender until the block owes nothing
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.parser_results.size() != 0);
    endtask

    function automatic logic [63:0] pick_value(int w);
        logic [63:0] mask;
        logic [63:0] v;
        mask = (64'd1 << w) - 64'd1;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       v = 64'd0;
            1:       v = mask;
            2, 3, 4: v = 64'($urandom_range(0, 300));
            5, 6:    v = v & ((64'd1 << $urandom_range(1, w)) - 64'd1);
            default: ;
        endcase
        return v & mask;
    endfunction

    // sdnv encoding, now and then with leading zero groups
    function automatic void push_sdnv(logic [63:0] v);
        int n;
        int pad;
        int i;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 64'd0)
            n++;
        pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
        repeat (pad) record_bytes.push_back(8'h80);
        for (i = n - 1; i >= 0; i--)
            record_bytes.push_back({i != 0, 7'(v >> (7 * i))});
    endfunction

    // one random record, mostly well formed
    function automatic void build_record();
        logic [3:0]  kind;
        logic [3:0]  flg;
        logic [3:0]  code;
        logic [3:0]  bad_field;
        logic [3:0]  fields[$];
        logic [63:0] v;
        bit          spoil;
        int          sel;
        int          w;
        int          eid_n;
        record_bytes.delete();
        sel  = $urandom_range(0, 19);
        kind = (sel < 9) ? TYPE_STATUS_REPORT :
               (sel < 18) ? TYPE_CUSTODY : 4'($urandom_range(0, 15));
        flg  = 4'($urandom_range(0, 15));
        record_bytes.push_back({kind, flg});
        if (kind == TYPE_STATUS_REPORT)
        begin
            record_bytes.push_back(8'($urandom_range(0, 255)));
            record_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind == TYPE_CUSTODY)
        begin
            record_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 3)) record_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        spoil     = ($urandom_range(0, 12) == 0);
        bad_field = 4'($urandom_range(FC_FOFF, FC_EIDLEN));
        if (flg[0])
        begin
            fields.push_back(FC_FOFF);
            fields.push_back(FC_FLEN);
        end
        fields.push_back(FC_EVS);
        fields.push_back(FC_EVNS);
        fields.push_back(FC_CREATE);
        fields.push_back(FC_SEQ);
        fields.push_back(FC_EIDLEN);
        eid_n = 0;
        foreach (fields[i])
        begin
            code = fields[i];
            w = (code == FC_FOFF || code == FC_FLEN || code == FC_EVNS) ? 32 :
                (code == FC_EIDLEN) ? 16 : 64;
            // too many groups for the field's range
            if (spoil && code == bad_field)
            begin
                record_bytes.push_back(8'h80 | 8'($urandom_range(1, 127)));
                repeat ((w + 6) / 7) record_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
                return;
            end
            if (code == FC_EIDLEN)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    v = pick_value(16);
                    eid_n = $urandom_range(0, 5);
                end
                else
                begin
                    v = 64'($urandom_range(0, 6));
                    eid_n = int'(v);
                end
            end
            else
            begin
                v = pick_value(w);
            end
            push_sdnv(v);
        end
        repeat (eid_n) record_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // send a record: whole, cut, unterminated, ended early, junk after, or loose bytes
    task automatic send_record();
        int mode;
        int cut;
        int last_at;
        int i;
        mode = $urandom_range(0, 19);
        if (mode == 0)
        begin
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0),
                          ($urandom_range(0, 3) == 0));
            return;
        end
        cut = record_bytes.size();
        if (mode <= 2)
            cut = $urandom_range(1, record_bytes.size());
        last_at = cut - 1;
        if (mode == 3)
            last_at = -1;
        else if (mode == 6)
            last_at = $urandom_range(0, cut - 1);
        for (i = 0; i < cut; i++)
            send_byte(record_bytes[i], (i == 0), (i == last_at));
        if (mode == 4 || mode == 5)
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    endtask

    // stimulus
    initial
    begin
        int base;
        int n_records;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_byte      = 8'd0;
        record_start = 1'b0;
        last_byte    = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // custody signal, one-byte sdnvs, zero eid length, then a byte after completion
        send_byte(8'h20, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        // unknown record types
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'h00, 1'b1, 1'b1);
        // last byte on the type byte
        send_byte(8'h1F, 1'b1, 1'b1);
        // status report with fragment: largest offset, then an oversized length
        send_byte(8'h11, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h8F, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b0);
        send_byte(8'h90, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b1);
        drain_results();

        // random records
        base = sb.n_parsed;
        n_records = 0;
        while (sb.n_parsed - base < RANDOM_ITEMS)
        begin
            build_record();
            send_record();
            n_records++;
            if (n_records % 20 == 0)
                drain_results();
        end

        drain_results();
        repeat (8) @(negedge clk);
        if (sb.n_errors == 0 && sb.parser_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
